### rtl/efc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efc_pkg;

    // Fixed field widths
    localparam int unsigned BTN_W   = 4;
    localparam int unsigned FLOOR_W = 2;
    localparam int unsigned COIL_W  = 4;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned PHASE_W = 3;

    // Direction codes as seen on the result beat
    localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // Car motion state
    typedef enum logic [2:0] {
        MOT_IDLE = 3'b001,
        MOT_UP   = 3'b010,
        MOT_DOWN = 3'b100
    } t_motion;

    typedef struct packed {
        logic [BTN_W-1:0]   floor_btn;
        logic [FLOOR_W-1:0] floor_now;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0]  coils;
        logic [DIR_W-1:0]   direction;
        logic [FLOOR_W-1:0] goal_floor;
        logic               goal_valid;
        logic [BTN_W-1:0]   pending;
        logic               chime;
    } t_out_item;

    // Controller state carried between beats
    typedef struct packed {
        logic [BTN_W-1:0]   req;
        logic [FLOOR_W-1:0] target;
        logic               target_set;
        t_motion            motion;
        logic               last_down;
        logic [PHASE_W-1:0] phase;
        logic [COIL_W-1:0]  coil_hold;
    } t_state;

    // Half-step coil pattern per phase
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        unique case (ph)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    function automatic logic [DIR_W-1:0] motion_code(input t_motion m);
        logic [DIR_W-1:0] code;
        unique case (m)
            MOT_UP:   code = DIR_UP;
            MOT_DOWN: code = DIR_DOWN;
            default:  code = DIR_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/efc_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One controller tick: next state and result beat from current state and input beat
module efc_step
    import efc_pkg::*;
#(
    parameter int unsigned NUM_FLOORS = 4
) (
    input  wire t_state    i_state,
    input  wire t_in_item  i_item,
    output t_state         o_state,
    output t_out_item      o_result
);

    localparam logic [4:0] TOP_FLOOR = 5'(NUM_FLOORS - 1);

    logic [BTN_W-1:0]   floor_mask;
    logic [FLOOR_W-1:0] here;
    logic [BTN_W-1:0]   req_tgl;
    logic               up_hit;
    logic [FLOOR_W-1:0] up_f;
    logic               dn_hit;
    logic [FLOOR_W-1:0] dn_f;
    t_state             s;
    logic               chime;

    // Floors that exist
    always_comb begin
        for (int f = 0; f < BTN_W; f++) begin
            floor_mask[f] = (f < NUM_FLOORS);
        end
    end

    // Sensor saturated to the top floor
    always_comb begin
        if ({3'b000, i_item.floor_now} > TOP_FLOOR) begin
            here = TOP_FLOOR[FLOOR_W-1:0];
        end else begin
            here = i_item.floor_now;
        end
    end

    assign req_tgl = (i_state.req ^ i_item.floor_btn) & floor_mask;

    // Nearest request above: lowest set floor beyond here
    always_comb begin
        up_hit = 1'b0;
        up_f   = '0;
        for (int f = BTN_W - 1; f >= 0; f--) begin
            if (req_tgl[f] && (FLOOR_W'(f) > here)) begin
                up_hit = 1'b1;
                up_f   = FLOOR_W'(f);
            end
        end
    end

    // Nearest request below: highest set floor under here
    always_comb begin
        dn_hit = 1'b0;
        dn_f   = '0;
        for (int f = 0; f < BTN_W; f++) begin
            if (req_tgl[f] && (FLOOR_W'(f) < here)) begin
                dn_hit = 1'b1;
                dn_f   = FLOOR_W'(f);
            end
        end
    end

    // Tick sequence
    always_comb begin
        s       = i_state;
        s.req   = req_tgl;
        chime   = 1'b0;

        // target pick from idle, last direction first
        if (!s.target_set && s.motion == MOT_IDLE) begin
            if (!s.last_down) begin
                if (up_hit) begin
                    s.target = up_f;
                    s.target_set = 1'b1;
                end else if (dn_hit) begin
                    s.target = dn_f;
                    s.target_set = 1'b1;
                end
            end else begin
                if (dn_hit) begin
                    s.target = dn_f;
                    s.target_set = 1'b1;
                end else if (up_hit) begin
                    s.target = up_f;
                    s.target_set = 1'b1;
                end
            end
        end

        // head toward target; idle at target just drops it
        if (s.target_set) begin
            priority if (s.target > here) begin
                s.motion = MOT_UP;
            end else if (s.target < here) begin
                s.motion = MOT_DOWN;
            end else if (s.motion == MOT_IDLE) begin
                s.req        = s.req & ~(BTN_W'(1) << s.target);
                s.target_set = 1'b0;
                s.target     = '0;
            end else begin
                // moving and at target: arrival handled with the step below
            end
        end

        // step the motor, then arrive or retarget ahead
        if (s.motion != MOT_IDLE) begin
            s.coil_hold = coil_pattern(s.phase);
            if (s.motion == MOT_UP) begin
                s.phase = s.phase + PHASE_W'(1);
            end else begin
                s.phase = s.phase - PHASE_W'(1);
            end

            if (s.target_set && s.target == here) begin
                s.req        = s.req & ~(BTN_W'(1) << s.target);
                s.last_down  = (s.motion == MOT_DOWN);
                s.motion     = MOT_IDLE;
                s.target_set = 1'b0;
                s.target     = '0;
                chime        = 1'b1;
            end else if (s.motion == MOT_UP) begin
                if (up_hit) begin
                    s.target = up_f;
                    s.target_set = 1'b1;
                end
            end else begin
                if (dn_hit) begin
                    s.target = dn_f;
                    s.target_set = 1'b1;
                end
            end
        end
    end

    assign o_state = s;

    always_comb begin
        o_result.coils      = s.coil_hold;
        o_result.direction  = motion_code(s.motion);
        o_result.goal_floor = s.target;
        o_result.goal_valid = s.target_set;
        o_result.pending    = s.req;
        o_result.chime      = chime;
    end

endmodule

`default_nettype wire

### rtl/elevator_floor_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Elevator floor controller: one result beat per input beat.
// The step logic sits between the input register and the result register.
// Throughput: 1 beat per cycle while i_out_stall is low; the whole tick is a single pass of the step logic.
// Reset (synchronous, active low): no requests, no target, car idle, last direction up,
// phase 0, coils off; both pipeline registers empty.
module elevator_floor_controller
    import efc_pkg::*;
#(
    parameter int unsigned NUM_FLOORS = 4
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output t_out_item      o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      advance;

    // Step logic
    efc_step #(
        .NUM_FLOORS(NUM_FLOORS)
    ) u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_result(n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.req        <= '0;
            r_state.target     <= '0;
            r_state.target_set <= 1'b0;
            r_state.motion     <= MOT_IDLE;
            r_state.last_down  <= 1'b0;
            r_state.phase      <= '0;
            r_state.coil_hold  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
